// ===== rtl/core/sckp_pkg.sv =====
// Package for the console serial line unit core.
// Holds command codes, register offsets, bit positions and the structs
// shared by sckp_csr, sckp_unit and the top level. No dependencies.
package sckp_pkg;

   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 16;
   localparam int CHAR_W  = 8;
   localparam int VEC_W   = 8;
   localparam int LEVEL_W = 3;
   localparam int CMD_W   = 3;

   localparam int WIN_BITS  = 3;
   localparam int BIT_FLAG  = 7;
   localparam int BIT_IE    = 6;
   localparam int BIT_MAINT = 2;
   localparam int BIT_CLEAR = 0;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] REG_KBD_VECTOR   = 2'd1;
   localparam logic [1:0] REG_PRT_VECTOR   = 2'd2;
   localparam logic [1:0] REG_BUS_LEVEL    = 2'd3;

   localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 16'hFF70;
   localparam logic [VEC_W-1:0]   RST_KBD_VECTOR   = 8'h30;
   localparam logic [VEC_W-1:0]   RST_PRT_VECTOR   = 8'h34;
   localparam logic [LEVEL_W-1:0] RST_BUS_LEVEL    = 3'd4;

   localparam logic [WIN_BITS-1:0] OFF_KBD_STAT = 3'd0;
   localparam logic [WIN_BITS-1:0] OFF_KBD_DATA = 3'd2;
   localparam logic [WIN_BITS-1:0] OFF_KBD_HIGH = 3'd3;
   localparam logic [WIN_BITS-1:0] OFF_PRT_STAT = 3'd4;
   localparam logic [WIN_BITS-1:0] OFF_PRT_DATA = 3'd6;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ       = 3'd0,
      CMD_WORD_WRITE = 3'd1,
      CMD_BYTE_WRITE = 3'd2,
      CMD_CHAR_RX    = 3'd3,
      CMD_PRT_DONE   = 3'd4,
      CMD_BUS_RESET  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base_address;
      logic [VEC_W-1:0]   keyboard_vector;
      logic [VEC_W-1:0]   printer_vector;
      logic [LEVEL_W-1:0] bus_level;
   } cfg_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [ADDR_W-1:0]  addr;
      logic [DATA_W-1:0]  write_data;
      logic [CHAR_W-1:0]  key_char;
   } item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] intr_level;
      logic [VEC_W-1:0]   intr_vector;
      logic               intr_valid;
      logic [CHAR_W-1:0]  print_char;
      logic               print_valid;
      logic [DATA_W-1:0]  read_data;
      logic               hit;
   } result_type;

endpackage

// ===== rtl/core/sckp_csr.sv =====
// Configuration registers of the console serial line unit core.
// APB-style write and read port; depends on sckp_pkg.
module sckp_csr
   import sckp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address    <= RST_BASE_ADDRESS;
         cfg_ff.keyboard_vector <= RST_KBD_VECTOR;
         cfg_ff.printer_vector  <= RST_PRT_VECTOR;
         cfg_ff.bus_level       <= RST_BUS_LEVEL;
      end else if (wr_en) begin
         case (reg_idx)
            REG_BASE_ADDRESS: cfg_ff.base_address    <= csr_pwdata[ADDR_W-1:0];
            REG_KBD_VECTOR:   cfg_ff.keyboard_vector <= csr_pwdata[VEC_W-1:0];
            REG_PRT_VECTOR:   cfg_ff.printer_vector  <= csr_pwdata[VEC_W-1:0];
            REG_BUS_LEVEL:    cfg_ff.bus_level       <= csr_pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         REG_BASE_ADDRESS: csr_prdata = {{(CSR_DATA_W-ADDR_W){1'b0}}, cfg_ff.base_address};
         REG_KBD_VECTOR:   csr_prdata = {{(CSR_DATA_W-VEC_W){1'b0}}, cfg_ff.keyboard_vector};
         REG_PRT_VECTOR:   csr_prdata = {{(CSR_DATA_W-VEC_W){1'b0}}, cfg_ff.printer_vector};
         REG_BUS_LEVEL:    csr_prdata = {{(CSR_DATA_W-LEVEL_W){1'b0}}, cfg_ff.bus_level};
         default:          csr_prdata = '0;
      endcase
   end

   a_level_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && reg_idx == REG_BUS_LEVEL |=> cfg_ff.bus_level == $past(csr_pwdata[LEVEL_W-1:0]))
      else $error("bus level register not loaded");
   a_hold_no_write: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(cfg_ff))
      else $error("configuration changed without a write");
   a_vec_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && reg_idx == REG_KBD_VECTOR |=> cfg_ff.keyboard_vector == $past(csr_pwdata[VEC_W-1:0]))
      else $error("keyboard vector register not loaded");

endmodule

// ===== rtl/core/sckp_unit.sv =====
// Register file and command decode of the console serial line unit.
// Holds keyboard and printer status; depends on sckp_pkg.
module sckp_unit
   import sckp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic              kbd_done_ff, kbd_done_in;
   logic              kbd_ie_ff, kbd_ie_in;
   logic [CHAR_W-1:0] kbd_char_ff, kbd_char_in;
   logic              prt_ready_ff, prt_ready_in;
   logic              prt_ie_ff, prt_ie_in;
   logic              prt_maint_ff, prt_maint_in;

   logic [ADDR_W-1:0] off;
   logic              in_window;
   logic              is_byte;
   logic [DATA_W-1:0] wval;

   always_comb begin
      kbd_done_in  = kbd_done_ff;
      kbd_ie_in    = kbd_ie_ff;
      kbd_char_in  = kbd_char_ff;
      prt_ready_in = prt_ready_ff;
      prt_ie_in    = prt_ie_ff;
      prt_maint_in = prt_maint_ff;
      result       = '0;
      off       = item.addr - cfg.base_address;
      in_window = (off[ADDR_W-1:WIN_BITS] == '0);
      is_byte   = (item.cmd == CMD_BYTE_WRITE);
      wval    = is_byte ? {{(DATA_W-CHAR_W){1'b0}}, item.write_data[CHAR_W-1:0]}
                        : item.write_data;
      case (item.cmd)
         CMD_READ: begin
            if (in_window) begin
               result.hit = 1'b1;
               case (off[WIN_BITS-1:0])
                  OFF_KBD_STAT: begin
                     result.read_data[BIT_FLAG] = kbd_done_ff;
                     result.read_data[BIT_IE]   = kbd_ie_ff;
                  end
                  OFF_KBD_DATA: begin
                     result.read_data = {{(DATA_W-CHAR_W){1'b0}}, kbd_char_ff};
                     kbd_done_in      = 1'b0;
                  end
                  OFF_PRT_STAT: begin
                     result.read_data[BIT_FLAG]  = prt_ready_ff;
                     result.read_data[BIT_IE]    = prt_ie_ff;
                     result.read_data[BIT_MAINT] = prt_maint_ff;
                  end
                  default: ;
               endcase
            end
         end
         CMD_WORD_WRITE, CMD_BYTE_WRITE: begin
            if (in_window) begin
               result.hit = 1'b1;
               case (off[WIN_BITS-1:0])
                  OFF_KBD_STAT: begin
                     kbd_ie_in = wval[BIT_IE];
                     if (wval[BIT_CLEAR]) begin
                        kbd_done_in = 1'b0;
                     end
                  end
                  OFF_KBD_DATA: kbd_done_in = 1'b0;
                  OFF_KBD_HIGH: begin
                     if (is_byte) begin
                        kbd_done_in = 1'b0;
                     end
                  end
                  OFF_PRT_STAT: begin
                     prt_ie_in    = wval[BIT_IE];
                     prt_maint_in = wval[BIT_MAINT];
                  end
                  OFF_PRT_DATA: begin
                     prt_ready_in       = 1'b0;
                     result.print_valid = 1'b1;
                     result.print_char  = wval[CHAR_W-1:0];
                  end
                  default: ;
               endcase
            end
         end
         CMD_CHAR_RX: begin
            kbd_char_in = item.key_char;
            kbd_done_in = 1'b1;
            if (kbd_ie_ff) begin
               result.intr_valid  = 1'b1;
               result.intr_vector = cfg.keyboard_vector;
               result.intr_level  = cfg.bus_level;
            end
         end
         CMD_PRT_DONE: begin
            if (!prt_ready_ff) begin
               prt_ready_in = 1'b1;
               if (prt_ie_ff) begin
                  result.intr_valid  = 1'b1;
                  result.intr_vector = cfg.printer_vector;
                  result.intr_level  = cfg.bus_level;
               end
            end
         end
         CMD_BUS_RESET: begin
            kbd_done_in  = 1'b0;
            kbd_ie_in    = 1'b0;
            prt_ready_in = 1'b1;
            prt_ie_in    = 1'b0;
            prt_maint_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kbd_done_ff  <= 1'b0;
         kbd_ie_ff    <= 1'b0;
         kbd_char_ff  <= '0;
         prt_ready_ff <= 1'b1;
         prt_ie_ff    <= 1'b0;
         prt_maint_ff <= 1'b0;
      end else if (fire) begin
         kbd_done_ff  <= kbd_done_in;
         kbd_ie_ff    <= kbd_ie_in;
         kbd_char_ff  <= kbd_char_in;
         prt_ready_ff <= prt_ready_in;
         prt_ie_ff    <= prt_ie_in;
         prt_maint_ff <= prt_maint_in;
      end
   end

   a_print_is_hit: assert property (@(posedge clock) disable iff (reset)
      fire && result.print_valid |-> result.hit && !result.intr_valid)
      else $error("printer character without a window hit");
   a_bus_reset: assert property (@(posedge clock) disable iff (reset)
      fire && item.cmd == CMD_BUS_RESET |=> prt_ready_ff && !kbd_done_ff && !kbd_ie_ff)
      else $error("bus reset left status set");
   a_char_done: assert property (@(posedge clock) disable iff (reset)
      fire && item.cmd == CMD_CHAR_RX |=> kbd_done_ff && kbd_char_ff == $past(item.key_char))
      else $error("received character not stored");
   a_print_clears_ready: assert property (@(posedge clock) disable iff (reset)
      fire && result.print_valid |=> !prt_ready_ff)
      else $error("printer data write left ready set");

endmodule

// ===== rtl/core/serial_console_keyboard_printer_regs_core.sv =====
// Top level of the console serial line unit core.
// Input register, register-file unit and result register;
// depends on sckp_pkg, sckp_csr and sckp_unit.
//
// Usage:
//   req_* carries one command per transaction (read, word write, byte
//   write, received character, printer done, bus reset); every command
//   yields exactly one transaction on rsp_*.
//   csr_* is an APB-style port for base address, the two interrupt
//   vectors and the bus request level; write it only while idle.
// Flow: an accepted command is held in the input register; its result is
//   then loaded into the result register and shown on rsp_*. Throughput:
//   one command per cycle while rsp_tready is high; each register holds one
//   transaction, and the status flags update when the result register loads.
// Reset: both registers empty, configuration at its defaults, keyboard
//   done clear and printer ready set.
// Stall: while rsp_tready is low the result holds, one more command can
//   wait in the input register, and then req_tready drops.
module serial_console_keyboard_printer_regs_core
   import sckp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] addr, [31:16] write_data, [39:32] key_char
   input  logic [39:0]           req_tdata,
   // [2:0] cmd
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] hit, [16:1] read_data, [17] print_valid, [25:18] print_char,
   // [26] intr_valid, [34:27] intr_vector, [37:35] intr_level, [39:38] zero
   output logic [39:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff;
   result_type res;
   result_type res_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, res_ff};

   sckp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sckp_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.cmd        <= cmd_type'(req_tuser);
         item_ff.addr       <= req_tdata[15:0];
         item_ff.write_data <= req_tdata[31:16];
         item_ff.key_char   <= req_tdata[39:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res;
      end
   end

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("result dropped while stalled");
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("pending command lost");
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register refused a command");

endmodule
